>>> rtl/mst_pkg.sv
package mst_pkg;

    localparam int SCORE_W    = 17;
    localparam int ROOT_W     = 16;
    localparam int FRAC_SHIFT = 24;
    localparam int MEAN_W     = 16;
    localparam int WS_W       = 6;

    localparam logic [1:0] OBS_POS = 2'd1;
    localparam logic [1:0] OBS_NEG = 2'd2;

    localparam logic [WS_W-1:0] WS_RESET = 6'd8;

    typedef struct packed {
        logic cfg_wr;
        logic accept;
        logic upd;
        logic sq_init;
        logic sq_step;
        logic sq_fin;
        logic sc_rd;
        logic sc_upd;
        logic fl_init;
        logic fl_drop;
        logic div_init;
        logic div_step;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic win_nx;
        logic last;
        logic sq_last;
        logic div_last;
        logic out_full;
        logic flush;
        logic fl_done;
        logic pend_zero;
    } t_sts;

endpackage

>>> rtl/mst_ctrl.sv
module mst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cfg_valid,
    input  mst_pkg::t_sts i_sts,
    output mst_pkg::t_cmd o_cmd,
    output logic          o_idle
);

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_SQI, S_SQ, S_RND, S_ADD, S_DIV0, S_DIV,
        S_EMIT, S_FLI, S_FRD, S_FDROP, S_CLR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.cfg_wr = 1'b1;
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_sts.win_nx) n_state = S_SQI;
                else if (i_sts.last) n_state = S_FLI;
                else n_state = S_IDLE;
            end
            S_SQI: begin
                o_cmd.sq_init = 1'b1;
                o_cmd.sc_rd   = 1'b1;
                n_state       = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) n_state = S_RND;
            end
            S_RND: begin
                o_cmd.sq_fin = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_cmd.sc_upd = 1'b1;
                n_state      = S_DIV0;
            end
            S_DIV0: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_full) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.flush) n_state = i_sts.fl_done ? S_CLR : S_FRD;
                    else if (i_sts.last) n_state = S_FLI;
                    else n_state = S_IDLE;
                end
            end
            S_FLI: begin
                o_cmd.fl_init = 1'b1;
                n_state       = i_sts.pend_zero ? S_CLR : S_FRD;
            end
            S_FRD: begin
                o_cmd.sc_rd = 1'b1;
                n_state     = S_FDROP;
            end
            S_FDROP: begin
                o_cmd.fl_drop = 1'b1;
                n_state       = S_DIV0;
            end
            S_CLR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

>>> rtl/mst_datapath.sv
module mst_datapath #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mst_pkg::t_cmd                     i_cmd,
    output mst_pkg::t_sts                     o_sts,
    input  logic [1:0]                        i_observation,
    input  logic                              i_last_sample,
    input  logic [mst_pkg::WS_W-1:0]          i_cfg_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [mst_pkg::MEAN_W-1:0] o_mean_score,
    output logic                              o_score_valid,
    output logic                              o_final_result
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = $clog2(MAX_WINDOW);
    localparam int AW = 2 * CW + mst_pkg::FRAC_SHIFT + 4;
    localparam int TW = mst_pkg::SCORE_W + CW;
    localparam int BW = $clog2(mst_pkg::ROOT_W);
    localparam int DW = $clog2(TW);
    localparam int SW = mst_pkg::SCORE_W;
    localparam int RW = mst_pkg::ROOT_W;
    localparam int MW = mst_pkg::MEAN_W;

    logic [mst_pkg::WS_W-1:0] r_ws;
    logic [CW-1:0]            w_k;
    logic [PW-1:0]            w_klast;

    logic [1:0]    r_hist [MAX_WINDOW];
    logic [1:0]    r_old;
    logic [1:0]    r_obs;
    logic          r_last;
    logic [PW-1:0] r_hptr;

    logic [CW-1:0] r_pres;
    logic [CW-1:0] r_posc;
    logic [CW-1:0] r_seen;
    logic          r_win;

    logic [AW-1:0] r_target;
    logic [AW-1:0] r_rr;
    logic [AW-1:0] r_rn;
    logic [RW-1:0] r_root;
    logic [BW-1:0] r_bit;
    logic [CW-1:0] r_n;
    logic          r_neg;

    logic signed [SW-1:0] r_smem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] r_sval;
    logic signed [SW-1:0] r_sold;
    logic                 r_sold_v;
    logic [PW-1:0]        r_sptr;
    logic signed [SW-1:0] r_e;
    logic                 r_e_v;

    logic signed [TW-1:0] r_total;
    logic [CW-1:0]        r_vcnt;

    logic [CW-1:0] r_rem;
    logic [TW-1:0] r_quo;
    logic [DW-1:0] r_dcnt;
    logic          r_tneg;

    logic          r_flush;
    logic [CW-1:0] r_pend;
    logic [CW-1:0] r_j;

    logic                 r_ov;
    logic signed [MW-1:0] r_mean;
    logic                 r_sv;
    logic                 r_fin;

    logic [CW-1:0]          w_seen_nx;
    logic                   w_old_p;
    logic                   w_old_pos;
    logic                   w_obs_p;
    logic                   w_obs_pos;
    logic signed [CW+1:0]   w_d;
    logic [CW:0]            w_mag;
    logic [2*CW+1:0]        w_d2;
    logic [AW-1:0]          w_cand;
    logic [AW-1:0]          w_fin_l;
    logic [RW-1:0]          w_root_r;
    logic [CW:0]            w_shift;
    logic [CW:0]            w_sub;
    logic [TW-1:0]          w_tabs;
    logic signed [TW-1:0]   w_drop;
    logic signed [TW-1:0]   w_add;
    logic [CW-1:0]          w_pend;
    logic [PW-1:0]          w_sptr_nx;
    logic [PW-1:0]          w_hptr_nx;
    logic [MW-1:0]          w_q16;

    always_comb begin
        if (r_ws == '0) begin
            w_k = CW'(1);
        end else if (int'(r_ws) > MAX_WINDOW) begin
            w_k = CW'(MAX_WINDOW);
        end else begin
            w_k = CW'(r_ws);
        end
    end

    assign w_klast   = PW'(w_k - CW'(1));
    assign w_hptr_nx = (r_hptr == w_klast) ? '0 : r_hptr + PW'(1);
    assign w_sptr_nx = (r_sptr == w_klast) ? '0 : r_sptr + PW'(1);

    assign w_old_p   = (r_old == mst_pkg::OBS_POS) || (r_old == mst_pkg::OBS_NEG);
    assign w_old_pos = (r_old == mst_pkg::OBS_POS);
    assign w_obs_p   = (r_obs == mst_pkg::OBS_POS) || (r_obs == mst_pkg::OBS_NEG);
    assign w_obs_pos = (r_obs == mst_pkg::OBS_POS);
    assign w_seen_nx = (r_seen < w_k) ? r_seen + CW'(1) : r_seen;

    assign w_d   = $signed({1'b0, r_posc, 1'b0}) - $signed({2'b00, r_pres});
    assign w_mag = w_d[CW+1] ? (CW+1)'(0) - w_d[CW:0] : w_d[CW:0];
    assign w_d2  = w_mag * w_mag;

    assign w_cand = r_rr + (r_rn << (r_bit + BW'(1))) + (AW'(r_n) << {r_bit, 1'b0});
    assign w_fin_l  = (r_rr << 2) + (r_rn << 2) + AW'(r_n);
    assign w_root_r = (w_fin_l < (r_target << 2)) ? r_root + RW'(1) : r_root;

    assign w_shift = {r_rem, r_quo[TW-1]};
    assign w_sub   = w_shift - {1'b0, r_vcnt};
    assign w_tabs  = r_total[TW-1] ? TW'(-r_total) : TW'(r_total);
    assign w_drop  = r_sold_v ? TW'(r_sold) : '0;
    assign w_add   = r_e_v ? TW'(r_e) : '0;
    assign w_pend  = r_win ? w_k - CW'(1) : r_seen;
    assign w_q16   = r_quo[MW-1:0];

    assign o_sts.win_nx    = (w_seen_nx == w_k);
    assign o_sts.last      = r_last;
    assign o_sts.sq_last   = (r_bit == '0);
    assign o_sts.div_last  = (r_dcnt == '0);
    assign o_sts.out_full  = r_ov && i_out_stall;
    assign o_sts.flush     = r_flush;
    assign o_sts.fl_done   = (r_j == r_pend);
    assign o_sts.pend_zero = (w_pend == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_old          <= r_hist[r_hptr];
            r_hist[r_hptr] <= i_observation;
        end
        if (i_cmd.sc_rd) begin
            r_sold <= r_smem[r_sptr];
        end
        if (i_cmd.sc_upd) begin
            r_smem[r_sptr] <= r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_obs  <= i_observation;
            r_last <= i_last_sample;
        end
        if (i_cmd.sq_init) begin
            r_target <= AW'(w_d2) << mst_pkg::FRAC_SHIFT;
            r_rr     <= '0;
            r_rn     <= '0;
            r_root   <= '0;
            r_bit    <= BW'(RW - 1);
            r_n      <= r_pres;
            r_neg    <= w_d[CW+1];
        end
        if (i_cmd.sq_step) begin
            if (w_cand <= r_target) begin
                r_root <= r_root | (RW'(1) << r_bit);
                r_rr   <= w_cand;
                r_rn   <= r_rn + (AW'(r_n) << r_bit);
            end
            r_bit <= r_bit - BW'(1);
        end
        if (i_cmd.sq_fin) begin
            r_e   <= r_neg ? -$signed(SW'(w_root_r)) : $signed(SW'(w_root_r));
            r_e_v <= (r_n > CW'(1));
        end
        if (i_cmd.sc_rd) begin
            r_sold_v <= r_sval[r_sptr];
        end
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= w_tabs;
            r_tneg <= r_total[TW-1];
            r_dcnt <= DW'(TW - 1);
        end
        if (i_cmd.div_step) begin
            if (w_shift >= {1'b0, r_vcnt}) begin
                r_rem <= w_sub[CW-1:0];
                r_quo <= {r_quo[TW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[CW-1:0];
                r_quo <= {r_quo[TW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - DW'(1);
        end
        if (i_cmd.emit) begin
            if (r_vcnt == '0) begin
                r_mean <= '0;
                r_sv   <= 1'b0;
            end else begin
                r_mean <= r_tneg ? -$signed(w_q16) : $signed(w_q16);
                r_sv   <= 1'b1;
            end
            r_fin <= r_flush ? (r_j == r_pend) : (r_last && (w_k == CW'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws    <= mst_pkg::WS_RESET;
            r_hptr  <= '0;
            r_pres  <= '0;
            r_posc  <= '0;
            r_seen  <= '0;
            r_win   <= 1'b0;
            r_sval  <= '0;
            r_sptr  <= '0;
            r_total <= '0;
            r_vcnt  <= '0;
            r_flush <= 1'b0;
            r_pend  <= '0;
            r_j     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.accept) r_hptr <= w_hptr_nx;
            if (i_cmd.upd) begin
                r_pres <= r_pres - CW'((r_seen >= w_k) && w_old_p) + CW'(w_obs_p);
                r_posc <= r_posc - CW'((r_seen >= w_k) && w_old_pos) + CW'(w_obs_pos);
                r_seen <= w_seen_nx;
                r_win  <= (w_seen_nx == w_k);
            end
            if (i_cmd.sc_upd) begin
                r_total        <= r_total - w_drop + w_add;
                r_vcnt         <= r_vcnt - CW'(r_sold_v) + CW'(r_e_v);
                r_sval[r_sptr] <= r_e_v;
                r_sptr         <= w_sptr_nx;
            end
            if (i_cmd.fl_init) begin
                r_flush <= 1'b1;
                r_pend  <= w_pend;
                r_j     <= '0;
            end
            if (i_cmd.fl_drop) begin
                r_total        <= r_total - w_drop;
                r_vcnt         <= r_vcnt - CW'(r_sold_v);
                r_sval[r_sptr] <= 1'b0;
                r_sptr         <= w_sptr_nx;
                r_j            <= r_j + CW'(1);
            end
            if (i_cmd.clear || i_cmd.cfg_wr) begin
                r_hptr  <= '0;
                r_pres  <= '0;
                r_posc  <= '0;
                r_seen  <= '0;
                r_win   <= 1'b0;
                r_sval  <= '0;
                r_sptr  <= '0;
                r_total <= '0;
                r_vcnt  <= '0;
                r_flush <= 1'b0;
                r_pend  <= '0;
                r_j     <= '0;
            end
            if (i_cmd.cfg_wr) r_ws <= i_cfg_data;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_mean_score   = r_mean;
    assign o_score_valid  = r_sv;
    assign o_final_result = r_fin;

endmodule

>>> rtl/moving_sign_test_smoother.sv
// Moving-window sign test smoother.
// Input channel: i_in_valid with o_in_stall carries one sample sign per item.
// Output channel: o_out_valid with i_out_stall carries one position result per
// item; a held result keeps its value until it is taken.
// Configuration: i_cfg_valid with o_cfg_ready writes the window size; the
// running sequence is dropped and no result is produced for it.
// An item that completes no window only updates the window counts. An item
// that completes a window also runs the bit-serial square root that scales
// the window score, updates the running score total and runs the bit-serial
// divider for the mean, all in one shared datapath.
// The last sample of a sequence then walks the remaining positions, one score
// dropped and one division each, plus steps to start and to end the flush.
// While the receiver stalls, the next result waits in the datapath and no
// item is accepted until that result has been loaded and the datapath is free.
// Synchronous active-low reset sets the window size to 8 and empties the
// sequence at once.
module moving_sign_test_smoother #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_observation,
    input  logic                              i_last_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [mst_pkg::MEAN_W-1:0] o_mean_score,
    output logic                              o_score_valid,
    output logic                              o_final_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mst_pkg::WS_W-1:0]          i_cfg_data
);

    mst_pkg::t_cmd w_cmd;
    mst_pkg::t_sts w_sts;
    logic          w_idle;

    mst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_idle      (w_idle)
    );

    mst_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_observation  (i_observation),
        .i_last_sample  (i_last_sample),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_mean_score   (o_mean_score),
        .o_score_valid  (o_score_valid),
        .o_final_result (o_final_result)
    );

    assign o_in_stall  = !w_idle || i_cfg_valid;
    assign o_cfg_ready = w_idle;

endmodule

>>> rtl/mst_checker.sv
module mst_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [mst_pkg::MEAN_W-1:0] o_mean_score,
    input logic                              o_score_valid,
    input logic                              o_final_result,
    input logic                              o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mean_score)
            && $stable(o_score_valid) && $stable(o_final_result))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall && !o_cfg_ready)
        else $error("block took a second item while one is at work");

    a_na_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_score_valid |-> o_mean_score == '0)
        else $error("NA result carries a nonzero mean");

    a_ready_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> o_cfg_ready)
        else $error("input open while configuration is closed");

endmodule

bind moving_sign_test_smoother mst_checker u_mst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_mean_score   (o_mean_score),
    .o_score_valid  (o_score_valid),
    .o_final_result (o_final_result),
    .o_cfg_ready    (o_cfg_ready)
);
